@@ src/u8ak_pkg.sv @@
// u8ak_pkg: shared types and constants for the utf-8 / arrow key decoder
// used by u8ak_step and utf8_and_arrow_key_decoder; no dependencies
`timescale 1ns / 1ps

package u8ak_pkg;

  // phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_UTF  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_ARROW = 2'd1;
  localparam logic [1:0] KIND_ESC   = 2'd2;

  // arrow directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // byte values
  localparam logic [7:0] BYTE_ESC     = 8'd27;
  localparam logic [7:0] BYTE_BRACKET = 8'h5B;
  localparam logic [7:0] BYTE_A       = 8'h41;
  localparam logic [7:0] BYTE_B       = 8'h42;
  localparam logic [7:0] BYTE_C       = 8'h43;
  localparam logic [7:0] BYTE_D       = 8'h44;

  localparam int unsigned CP_W = 21;

  // decoder state carried between items
  typedef struct packed {
    logic [1:0]      phase;
    logic [1:0]      bytes_left;
    logic [CP_W-1:0] accum;
    logic            bracket_seen;
  } dec_state_t;

  // one result item
  typedef struct packed {
    logic [1:0]      kind;
    logic [CP_W-1:0] code_point;
    logic [1:0]      dir;
  } dec_result_t;

endpackage

@@ src/u8ak_step.sv @@
// u8ak_step: next-state and result logic for one input byte
// depends on u8ak_pkg
`timescale 1ns / 1ps

module u8ak_step (
  input  u8ak_pkg::dec_state_t  cur_state,
  input  logic [7:0]            data_byte,
  output u8ak_pkg::dec_state_t  nxt_state,
  output logic                  res_vld,
  output u8ak_pkg::dec_result_t res
);
  import u8ak_pkg::*;

  logic [CP_W-1:0] accum_shift;
  logic [1:0]      left_dec;

  // continuation byte contributes its low six bits
  assign accum_shift = {cur_state.accum[CP_W-7:0], data_byte[5:0]};
  assign left_dec    = cur_state.bytes_left - 2'd1;

  always_comb begin
    nxt_state      = cur_state;
    res_vld        = 1'b0;
    res.kind       = KIND_CHAR;
    res.code_point = '0;
    res.dir        = DIR_UP;
    case (cur_state.phase)
      // two bytes after esc
      PH_ESC: begin
        if (cur_state.bytes_left >= 2'd2) begin
          nxt_state.bracket_seen = (data_byte == BYTE_BRACKET);
          nxt_state.bytes_left   = 2'd1;
        end else begin
          nxt_state.phase        = PH_IDLE;
          nxt_state.bytes_left   = 2'd0;
          nxt_state.bracket_seen = 1'b0;
          res_vld                = 1'b1;
          res.kind               = KIND_ESC;
          if (cur_state.bracket_seen) begin
            case (data_byte)
              BYTE_A: begin res.kind = KIND_ARROW; res.dir = DIR_UP;    end
              BYTE_C: begin res.kind = KIND_ARROW; res.dir = DIR_RIGHT; end
              BYTE_B: begin res.kind = KIND_ARROW; res.dir = DIR_DOWN;  end
              BYTE_D: begin res.kind = KIND_ARROW; res.dir = DIR_LEFT;  end
              default: res.kind = KIND_ESC;
            endcase
          end
        end
      end
      // open utf-8 sequence
      PH_UTF: begin
        nxt_state.accum      = accum_shift;
        nxt_state.bytes_left = left_dec;
        if (left_dec == 2'd0) begin
          nxt_state.phase = PH_IDLE;
          nxt_state.accum = '0;
          res_vld         = 1'b1;
          res.code_point  = accum_shift;
        end
      end
      // idle, also the unused phase code
      default: begin
        nxt_state.phase = PH_IDLE;
        if (data_byte == BYTE_ESC) begin
          nxt_state.phase        = PH_ESC;
          nxt_state.bytes_left   = 2'd2;
          nxt_state.bracket_seen = 1'b0;
        end else if (data_byte[7:5] == 3'b110) begin
          nxt_state.accum      = {{(CP_W-5){1'b0}}, data_byte[4:0]};
          nxt_state.bytes_left = 2'd1;
          nxt_state.phase      = PH_UTF;
        end else if (data_byte[7:4] == 4'b1110) begin
          nxt_state.accum      = {{(CP_W-4){1'b0}}, data_byte[3:0]};
          nxt_state.bytes_left = 2'd2;
          nxt_state.phase      = PH_UTF;
        end else if (data_byte[7:3] == 5'b11110) begin
          nxt_state.accum      = {{(CP_W-3){1'b0}}, data_byte[2:0]};
          nxt_state.bytes_left = 2'd3;
          nxt_state.phase      = PH_UTF;
        end else begin
          res_vld        = 1'b1;
          res.code_point = {{(CP_W-8){1'b0}}, data_byte};
        end
      end
    endcase
  end

endmodule

@@ src/utf8_and_arrow_key_decoder.sv @@
// utf8_and_arrow_key_decoder: terminal byte stream to keys (utf-8 and esc [ A..D)
// depends on u8ak_pkg and u8ak_step
//
//   port group | dir | payload                                         | handshake
//   in_        | in  | data_byte[7:0]                                  | in_valid / in_stall
//   out_       | out | result_kind[1:0] code_point[20:0] arrow_dir[1:0] | out_valid / out_stall
//
// one byte per cycle unless stalled: input register, one level of decode logic, result register
// a byte moves from the input register through the decode logic into the result register
// a byte that completes no key gives no result item
// out_stall holds the result register and, through it, the input register
// synchronous active-low reset clears valids and returns the decoder to idle
`timescale 1ns / 1ps

module utf8_and_arrow_key_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [20:0] out_code_point,
  output logic [1:0]  out_arrow_dir
);
  import u8ak_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  dec_state_t  st_r;
  dec_state_t  st_nxt;
  logic        res_vld_nxt;
  dec_result_t res_nxt;
  logic        out_vld_r;
  dec_result_t res_r;
  logic        advance;

  // the held byte is decoded when the result register can take it
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  u8ak_step u_step (
    .cur_state (st_r),
    .data_byte (in_byte_r),
    .nxt_state (st_nxt),
    .res_vld   (res_vld_nxt),
    .res       (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, bytes_left: 2'd0, accum: '0, bracket_seen: 1'b0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r <= advance && res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld_nxt) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = res_r.kind;
  assign out_code_point  = res_r.code_point;
  assign out_arrow_dir   = res_r.dir;

  // checks on decoder bookkeeping and result shape
  a_utf_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_UTF |-> st_r.bytes_left != 2'd0)
    else $error("utf phase with no bytes left");

  a_esc_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_ESC |-> (st_r.bytes_left == 2'd1 || st_r.bytes_left == 2'd2))
    else $error("esc phase with bad byte count");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.kind != 2'd3)
    else $error("result kind out of range");

  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.kind != KIND_CHAR) |-> res_r.code_point == '0)
    else $error("code point set on a non-character result");

  a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.kind != KIND_ARROW) |-> res_r.dir == DIR_UP)
    else $error("direction set on a non-arrow result");

endmodule
